>>> rtl/vocal_level_rider_defines.svh
// Assertion macros for the vocal level rider RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef VOCAL_LEVEL_RIDER_DEFINES_SVH
`define VOCAL_LEVEL_RIDER_DEFINES_SVH

// same-cycle implication
`define VLR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VLR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vlr_pkg.sv
// Package for the vocal level rider: register codes, reset values, fixed-point
// constants and rounding helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vlr_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [23:0]                gain_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_ACTIVE_CH  = 3'd0;
  localparam cfg_idx_t REG_ATTACK     = 3'd1;
  localparam cfg_idx_t REG_RELEASE    = 3'd2;
  localparam cfg_idx_t REG_SMOOTH     = 3'd3;
  localparam cfg_idx_t REG_TARGET     = 3'd4;
  localparam cfg_idx_t REG_SILENCE    = 3'd5;
  localparam cfg_idx_t REG_MAX_CUT    = 3'd6;
  localparam cfg_idx_t REG_MAX_BOOST  = 3'd7;

  // reset values
  localparam logic [1:0]         RST_ACTIVE_CH = 2'd2;
  localparam logic [23:0]        RST_ATTACK    = 24'd16743111;
  localparam logic [23:0]        RST_RELEASE   = 24'd16775468;
  localparam logic [23:0]        RST_SMOOTH    = 24'd16774072;
  localparam logic signed [15:0] RST_TARGET    = -16'sd4608;
  localparam logic signed [16:0] RST_SILENCE   = -17'sd15360;
  localparam logic [12:0]        RST_MAX_CUT   = 13'd1536;
  localparam logic [12:0]        RST_MAX_BOOST = 13'd1536;

  // fixed-point constants
  localparam logic signed [16:0] DB_FLOOR_Q8     = -17'sd46080;
  localparam logic [21:0]        DB_FLOOR_MAG    = 22'd46080;
  localparam logic [18:0]        DB_PER_LOG2_Q16 = 19'd394566;
  localparam logic [15:0]        SCALE_065_Q16   = 16'd42598;
  localparam logic [21:0]        LOG2_PER_DB_Q24 = 22'd2786635;
  localparam logic [24:0]        ONE_Q24         = 25'd16777216;
  localparam logic [21:0]        LOG2_TOP_Q16    = 22'd2031616;  // 31.0 in Q.16
  localparam logic [31:0]        ENV_MAX         = 32'h8000_0000;
  localparam logic signed [31:0] GDB_LIMIT       = 32'sd33554432;

  // degree-5 Taylor of 2^f in Q2.30, highest term first
  localparam logic [31:0] HORNER_INIT = 32'd1431680;
  localparam logic [31:0] HORNER_COEF [0:4] = '{
    32'd10327388, 32'd59597083, 32'd257941246, 32'd744261118, 32'd1073741824
  };

  // divide by 2^s, round to nearest, halves away from zero
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input int unsigned s);
    logic [65:0] mag;
    logic [65:0] half;
    mag  = v[65] ? 66'(-v) : 66'(v);
    half = 66'd1 << (s - 1);
    mag  = (mag + half) >> s;
    return v[65] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic sample_t sat_sample(input logic signed [65:0] v);
    if (v > 66'sd8388607)
      return 24'sh7FFFFF;
    else if (v < -66'sd8388608)
      return 24'sh800000;
    else
      return v[23:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/vlr_ifs.sv
// Handshake channel interfaces for the vocal level rider: input frames,
// result words and configuration writes. Depends on vlr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vlr_in_if;
  logic              valid;
  logic              ready;
  vlr_pkg::sample_t  sample_ch0;
  vlr_pkg::sample_t  sample_ch1;
  modport source(output valid, output sample_ch0, output sample_ch1, input ready);
  modport sink(input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

interface vlr_out_if;
  logic              valid;
  logic              ready;
  vlr_pkg::sample_t  out_ch0;
  vlr_pkg::sample_t  out_ch1;
  vlr_pkg::gain_t    gain_linear;
  modport source(output valid, output out_ch0, output out_ch1, output gain_linear,
                 input ready);
  modport sink(input valid, input out_ch0, input out_ch1, input gain_linear,
               output ready);
endinterface

interface vlr_cfg_if;
  logic                valid;
  logic                ready;
  vlr_pkg::cfg_idx_t   index;
  vlr_pkg::cfg_data_t  data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/vocal_level_rider.sv
// Vocal level rider: one frame in, one word out. A frame is not taken until the word
// of the last one is in the output register, so any output hold-off delays it.
// One shared 33x33 multiplier under a sequencer sets the time: the envelope log takes
// 16 squarings plus up to 31 single-bit normalize steps (skipped for a silent
// envelope), the exp takes 5 Horner steps. Input is not ready while a frame is in work.
// Sync active-low reset: registers to defaults, envelope 0, gain 0 dB. Needs vlr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "vocal_level_rider_defines.svh"
module vocal_level_rider (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vlr_cfg_if.sink    cfg_ch,
  vlr_in_if.sink     in_ch,
  vlr_out_if.source  out_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_ENV_A, S_ENV_B, S_ENV_C, S_NORM, S_SQ_MUL, S_SQ_UPD, S_LVL_MUL,
    S_LVL, S_DES, S_DES_MUL, S_DES_FIN, S_SM_A, S_SM_B, S_SM_C, S_EXP_MUL,
    S_EXP, S_HORN_MUL, S_HORN, S_SCALE, S_OUT0_MUL, S_OUT1_MUL, S_OUT1, S_DONE
  } state_t;

  // configuration
  logic [1:0]         active_ch_r;
  logic [23:0]        attack_r, release_r, smooth_r;
  logic signed [15:0] target_r;
  logic signed [16:0] silence_r;
  logic [12:0]        max_cut_r, max_boost_r;

  state_t              state_r;
  vlr_pkg::sample_t    s0_r, s1_r;
  logic                stereo_r;
  logic [31:0]         x_r;
  logic [23:0]         coef_a_r;
  logic [31:0]         env_r;
  logic signed [31:0]  gdb_r;
  logic [31:0]         y_r;
  logic [4:0]          p_r;
  logic [15:0]         frac_r;
  logic [3:0]          cnt_r;
  logic signed [16:0]  lvl_r;
  logic signed [13:0]  d_r;
  logic                ride_r;
  logic signed [25:0]  desired_r;
  logic signed [57:0]  acc_r;
  logic signed [10:0]  n_r;
  logic [29:0]         f_r;
  logic [31:0]         hacc_r;
  vlr_pkg::gain_t      gain_r;
  vlr_pkg::sample_t    o0_r, o1_r;
  logic                out_valid_r;
  vlr_pkg::sample_t    out0_r, out1_r;
  vlr_pkg::gain_t      out_gain_r;

  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_r;

  logic                in_acc;
  logic signed [24:0]  pair_sum;
  logic signed [23:0]  mono;
  logic [23:0]         mono_mag;
  logic [23:0]         a_sel;
  logic [57:0]         env_sum;
  logic [31:0]         env_new;
  logic [34:0]         sq;
  logic [21:0]         log_m;
  logic [45:0]         lvl_t;
  logic signed [17:0]  diff;
  logic signed [17:0]  cut_neg, boost_pos;
  logic signed [65:0]  rnd_des, rnd_gdb, rnd_e, rnd_out;
  logic [30:0]         e_val;
  logic [5:0]          sh_r;
  logic [39:0]         sh_val;
  vlr_pkg::gain_t      gain_nxt;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_ch0     = out0_r;
  assign out_ch.out_ch1     = out1_r;
  assign out_ch.gain_linear = out_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ch_r <= vlr_pkg::RST_ACTIVE_CH;
      attack_r    <= vlr_pkg::RST_ATTACK;
      release_r   <= vlr_pkg::RST_RELEASE;
      smooth_r    <= vlr_pkg::RST_SMOOTH;
      target_r    <= vlr_pkg::RST_TARGET;
      silence_r   <= vlr_pkg::RST_SILENCE;
      max_cut_r   <= vlr_pkg::RST_MAX_CUT;
      max_boost_r <= vlr_pkg::RST_MAX_BOOST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vlr_pkg::REG_ACTIVE_CH: active_ch_r <= cfg_ch.data[1:0];
        vlr_pkg::REG_ATTACK:    attack_r    <= cfg_ch.data;
        vlr_pkg::REG_RELEASE:   release_r   <= cfg_ch.data;
        vlr_pkg::REG_SMOOTH:    smooth_r    <= cfg_ch.data;
        vlr_pkg::REG_TARGET:    target_r    <= cfg_ch.data[15:0];
        vlr_pkg::REG_SILENCE:   silence_r   <= cfg_ch.data[16:0];
        vlr_pkg::REG_MAX_CUT:   max_cut_r   <= cfg_ch.data[12:0];
        vlr_pkg::REG_MAX_BOOST: max_boost_r <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end

  // mono mix and magnitude at accept
  always_comb begin
    pair_sum = 25'(in_ch.sample_ch0) + 25'(in_ch.sample_ch1);
    mono     = active_ch_r[1] ? pair_sum[24:1] : in_ch.sample_ch0;
    mono_mag = mono[23] ? 24'(-mono) : 24'(mono);
  end

  // shared multiplier operand select
  always_comb begin
    a_sel = (x_r > env_r) ? attack_r : release_r;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ENV_A: begin
        mul_a = {9'b0, a_sel};
        mul_b = {1'b0, env_r};
      end
      S_ENV_B: begin
        mul_a = {8'b0, vlr_pkg::ONE_Q24 - {1'b0, coef_a_r}};
        mul_b = {1'b0, x_r};
      end
      S_SQ_MUL: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      S_LVL_MUL: begin
        mul_a = {11'b0, log_m};
        mul_b = {14'b0, vlr_pkg::DB_PER_LOG2_Q16};
      end
      S_DES_MUL: begin
        mul_a = {{19{d_r[13]}}, d_r};
        mul_b = {17'b0, vlr_pkg::SCALE_065_Q16};
      end
      S_SM_A: begin
        mul_a = {9'b0, smooth_r};
        mul_b = {gdb_r[31], gdb_r};
      end
      S_SM_B: begin
        mul_a = {8'b0, vlr_pkg::ONE_Q24 - {1'b0, smooth_r}};
        mul_b = {{7{desired_r[25]}}, desired_r};
      end
      S_EXP_MUL: begin
        mul_a = {gdb_r[31], gdb_r};
        mul_b = {11'b0, vlr_pkg::LOG2_PER_DB_Q24};
      end
      S_HORN_MUL: begin
        mul_a = {1'b0, hacc_r};
        mul_b = {3'b0, f_r};
      end
      S_OUT0_MUL: begin
        mul_a = {{9{s0_r[23]}}, s0_r};
        mul_b = {9'b0, gain_r};
      end
      S_OUT1_MUL: begin
        mul_a = {{9{s1_r[23]}}, s1_r};
        mul_b = {9'b0, gain_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // datapath terms read from the product register
  always_comb begin
    env_sum   = 58'(acc_r) + prod_r[57:0] + 58'd8388608;
    env_new   = env_sum[55:24];
    sq        = prod_r[65:31];
    log_m     = vlr_pkg::LOG2_TOP_Q16 - {1'b0, p_r, frac_r};
    lvl_t     = prod_r[45:0] + 46'd8388608;
    diff      = 18'(target_r) - 18'(lvl_r);
    cut_neg   = -$signed({5'b0, max_cut_r});
    boost_pos = $signed({5'b0, max_boost_r});
    rnd_des   = vlr_pkg::rnd_shift(prod_r, 4);
    rnd_gdb   = vlr_pkg::rnd_shift(66'(acc_r) + prod_r, 24);
    rnd_e     = vlr_pkg::rnd_shift(prod_r, 24);
    rnd_out   = vlr_pkg::rnd_shift(prod_r, 20);
    e_val     = rnd_e[30:0];
    sh_r      = 6'(11'sd10 - n_r);
    sh_val    = ({8'b0, hacc_r} + (40'd1 << (sh_r - 6'd1))) >> sh_r;
    if (n_r >= 11'sd4)
      gain_nxt = 24'hFFFFFF;
    else if (n_r <= -11'sd30)
      gain_nxt = '0;
    else if (sh_val > 40'hFFFFFF)
      gain_nxt = 24'hFFFFFF;
    else
      gain_nxt = sh_val[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_r       <= '0;
      gdb_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // S_DONE sets or holds the valid flag itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE)
        out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            s0_r     <= in_ch.sample_ch0;
            s1_r     <= in_ch.sample_ch1;
            stereo_r <= active_ch_r[1];
            x_r      <= {mono_mag, 8'b0};
            state_r  <= S_ENV_A;
          end
        end
        S_ENV_A: begin
          coef_a_r <= a_sel;
          state_r  <= S_ENV_B;
        end
        S_ENV_B: begin
          acc_r   <= prod_r[57:0];
          state_r <= S_ENV_C;
        end
        S_ENV_C: begin
          env_r <= env_new;
          y_r   <= env_new;
          p_r   <= 5'd31;
          if (env_new == '0) begin
            lvl_r   <= vlr_pkg::DB_FLOOR_Q8;
            state_r <= S_DES;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // one bit of normalize per cycle
          if (y_r[31]) begin
            cnt_r   <= '0;
            frac_r  <= '0;
            state_r <= S_SQ_MUL;
          end else begin
            y_r <= {y_r[30:0], 1'b0};
            p_r <= p_r - 5'd1;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_UPD;
        S_SQ_UPD: begin
          if (sq[32]) begin
            y_r    <= sq[32:1];
            frac_r <= {frac_r[14:0], 1'b1};
          end else begin
            y_r    <= sq[31:0];
            frac_r <= {frac_r[14:0], 1'b0};
          end
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == 4'd15) ? S_LVL_MUL : S_SQ_MUL;
        end
        S_LVL_MUL: state_r <= S_LVL;
        S_LVL: begin
          if (lvl_t[45:24] > vlr_pkg::DB_FLOOR_MAG)
            lvl_r <= vlr_pkg::DB_FLOOR_Q8;
          else
            lvl_r <= -$signed({1'b0, lvl_t[39:24]});
          state_r <= S_DES;
        end
        S_DES: begin
          ride_r <= (lvl_r > silence_r);
          if (diff < cut_neg)
            d_r <= cut_neg[13:0];
          else if (diff > boost_pos)
            d_r <= boost_pos[13:0];
          else
            d_r <= diff[13:0];
          state_r <= S_DES_MUL;
        end
        S_DES_MUL: state_r <= S_DES_FIN;
        S_DES_FIN: begin
          desired_r <= ride_r ? rnd_des[25:0] : '0;
          state_r   <= S_SM_A;
        end
        S_SM_A: state_r <= S_SM_B;
        S_SM_B: begin
          acc_r   <= prod_r[57:0];
          state_r <= S_SM_C;
        end
        S_SM_C: begin
          gdb_r   <= rnd_gdb[31:0];
          state_r <= S_EXP_MUL;
        end
        S_EXP_MUL: state_r <= S_EXP;
        S_EXP: begin
          n_r     <= e_val[30:20];
          f_r     <= {e_val[19:0], 10'b0};
          hacc_r  <= vlr_pkg::HORNER_INIT;
          cnt_r   <= '0;
          state_r <= S_HORN_MUL;
        end
        S_HORN_MUL: state_r <= S_HORN;
        S_HORN: begin
          hacc_r  <= vlr_pkg::HORNER_COEF[cnt_r[2:0]] + prod_r[61:30];
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == 4'd4) ? S_SCALE : S_HORN_MUL;
        end
        S_SCALE: begin
          gain_r  <= gain_nxt;
          state_r <= S_OUT0_MUL;
        end
        S_OUT0_MUL: state_r <= S_OUT1_MUL;
        S_OUT1_MUL: begin
          o0_r    <= vlr_pkg::sat_sample(rnd_out);
          state_r <= S_OUT1;
        end
        S_OUT1: begin
          o1_r    <= stereo_r ? vlr_pkg::sat_sample(rnd_out) : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out0_r      <= o0_r;
            out1_r      <= o1_r;
            out_gain_r  <= gain_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VLR_ASSERT_NXT(a_accept_starts, in_acc, state_r == S_ENV_A, "accept did not start a frame")
  `VLR_ASSERT_IMP(a_env_bound, 1'b1, env_r <= vlr_pkg::ENV_MAX, "envelope above full scale")
  `VLR_ASSERT_IMP(a_norm_nonzero, state_r == S_NORM, y_r != '0, "normalize on zero envelope")
  `VLR_ASSERT_IMP(a_gdb_bound, 1'b1, (gdb_r <= vlr_pkg::GDB_LIMIT) && (gdb_r >= -vlr_pkg::GDB_LIMIT), "smoothed gain out of range")
  `VLR_ASSERT_IMP(a_horn_cnt, state_r == S_HORN, cnt_r <= 4'd4, "Horner step count overrun")

endmodule
`default_nettype wire
